// File: src/shs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Source hash server select package
// Shared types, field widths and codes for the server select block.
// ----------------------------------------------------------------------------
package shs_pkg;

  localparam int SLOT_W   = 4;
  localparam int ID_W     = 16;
  localparam int ENTRY_W  = 16;
  localparam int ADDR_W   = 32;
  localparam int BUCKET_W = 16;
  localparam int STATUS_W = 2;
  localparam int SC_W     = 5;
  localparam int RES_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [ADDR_W-1:0] GOLDEN_MULT = 32'd2654435761;

  localparam logic [STATUS_W-1:0] ST_SELECTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_WRITTEN  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED     = 1'd1;

  localparam logic REQ_SELECT = 1'b0;
  localparam logic REQ_WRITE  = 1'b1;

  typedef struct packed {
    logic [SC_W-1:0]  server_count;
    logic [RES_W-1:0] reserved;
  } shs_cfg_t;

  typedef struct packed {
    logic                req_type;
    logic [BUCKET_W-1:0] bucket;
    logic [SLOT_W-1:0]   slot;
    logic [ID_W-1:0]     id;
    logic [ENTRY_W-1:0]  load;
    logic [ENTRY_W-1:0]  limit;
  } shs_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_READ,
    BK_CHECK,
    BK_EMIT
  } shs_bk_state_t;

endpackage
`default_nettype wire

// File: src/shs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Source hash server select front end
// Accepts input transactions, hashes the source address into a bucket and
// hands the classified item to the queue.
// ----------------------------------------------------------------------------
module shs_front #(
  parameter int HASH_BUCKETS = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_req_type,
  input  wire logic [shs_pkg::ADDR_W-1:0]  in_source_address,
  input  wire logic [shs_pkg::SLOT_W-1:0]  in_slot_index,
  input  wire logic [shs_pkg::ID_W-1:0]    in_entry_id,
  input  wire logic [shs_pkg::ENTRY_W-1:0] in_entry_load,
  input  wire logic [shs_pkg::ENTRY_W-1:0] in_entry_limit,
  output logic                             f_valid,
  input  wire logic                        f_ready,
  output shs_pkg::shs_item_t               f_item
);
  import shs_pkg::*;

  localparam int HB = $clog2(HASH_BUCKETS);
  localparam logic [HB-1:0] GOLD_LO = GOLDEN_MULT[HB-1:0];

  logic            f_valid_r;
  shs_item_t       f_item_r;
  logic [HB-1:0]   bucket;
  logic            accept;

  assign in_ready = !f_valid_r || f_ready;
  assign accept   = in_valid && in_ready;
  assign bucket   = in_source_address[HB-1:0] * GOLD_LO;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (accept) begin
      f_valid_r <= 1'b1;
    end else if (f_ready) begin
      f_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item_r.req_type <= in_req_type;
      f_item_r.bucket   <= BUCKET_W'(bucket);
      f_item_r.slot     <= in_slot_index;
      f_item_r.id       <= in_entry_id;
      f_item_r.load     <= in_entry_load;
      f_item_r.limit    <= in_entry_limit;
    end
  end

  assign f_valid = f_valid_r;
  assign f_item  = f_item_r;

endmodule
`default_nettype wire

// File: src/shs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Source hash server select queue
// Two-entry FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module shs_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_valid,
  output logic                    wr_ready,
  input  wire shs_pkg::shs_item_t wr_item,
  output logic                    rd_valid,
  input  wire logic               rd_ready,
  output shs_pkg::shs_item_t      rd_item
);
  import shs_pkg::*;

  shs_item_t   q_mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic        push;
  logic        pop;

  assign wr_ready = count_r != 2'd2;
  assign rd_valid = count_r != 2'd0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_item  = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      priority if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end else begin
        count_r <= count_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule
`default_nettype wire

// File: src/shs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Source hash server select back end
// Holds the server table, reduces the bucket modulo the server count one bit
// per cycle, probes the table slot by slot and drives the output register.
// ----------------------------------------------------------------------------
module shs_back #(
  parameter int MAX_SERVERS  = 16,
  parameter int HASH_BUCKETS = 256,
  parameter int LOAD_BITS    = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire shs_pkg::shs_cfg_t            cfg,
  input  wire logic                         q_valid,
  output logic                              q_ready,
  input  wire shs_pkg::shs_item_t           q_item,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [shs_pkg::STATUS_W-1:0]      out_status,
  output logic [shs_pkg::ID_W-1:0]          out_chosen_id,
  output logic [shs_pkg::SLOT_W-1:0]        out_chosen_slot
);
  import shs_pkg::*;

  localparam int HB  = $clog2(HASH_BUCKETS);
  localparam int DCW = $clog2(HB + 1);
  localparam int SW  = $clog2(MAX_SERVERS);
  localparam int CW  = $clog2(MAX_SERVERS + 1);
  localparam int LB  = LOAD_BITS;
  localparam int MW  = ID_W + 2 * LB;
  localparam int NW  = ((LB > RES_W) ? LB : RES_W) + 1;

  shs_bk_state_t state_r, state_nxt;

  logic [MW-1:0]        tbl_mem [MAX_SERVERS];
  logic [MW-1:0]        rd_data_r;
  logic [CW-1:0]        rem_r;
  logic [HB-1:0]        dvd_r;
  logic [DCW-1:0]       div_cnt_r;
  logic [SW-1:0]        pos_r;
  logic [CW-1:0]        k_r;
  logic [STATUS_W-1:0]  res_status_r;
  logic [ID_W-1:0]      res_id_r;
  logic [SLOT_W-1:0]    res_slot_r;
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [ID_W-1:0]      out_id_r;
  logic [SLOT_W-1:0]    out_slot_r;

  logic [CW-1:0]        n_eff;
  logic [CW:0]          div_try;
  logic [CW-1:0]        rem_nxt;
  logic [CW-1:0]        pos_inc;
  logic [SW-1:0]        pos_wrap;
  logic [ID_W-1:0]      rd_id;
  logic [LB-1:0]        rd_load;
  logic [LB-1:0]        rd_limit;
  logic [NW-1:0]        need;
  logic                 hit;
  logic                 last_probe;
  logic                 div_done;
  logic                 slot_ok;
  logic [SW-1:0]        wr_addr;
  logic                 mem_we;
  logic                 out_load;
  logic [31:0]          pos_wide;

  always_comb begin
    priority if (cfg.server_count == '0) begin
      n_eff = CW'(1);
    end else if (32'(cfg.server_count) > MAX_SERVERS) begin
      n_eff = CW'(MAX_SERVERS);
    end else begin
      n_eff = CW'(cfg.server_count);
    end
  end

  assign div_try  = {rem_r, dvd_r[HB-1]};
  assign rem_nxt  = (div_try >= {1'b0, n_eff}) ? CW'(div_try - {1'b0, n_eff}) : CW'(div_try);
  assign div_done = div_cnt_r == DCW'(1);

  assign pos_inc    = CW'(pos_r) + CW'(1);
  assign pos_wrap   = (pos_inc >= n_eff) ? '0 : SW'(pos_inc);
  assign last_probe = (k_r + CW'(1)) == n_eff;
  assign pos_wide   = 32'(pos_r);

  assign rd_id    = rd_data_r[MW-1 -: ID_W];
  assign rd_load  = rd_data_r[2*LB-1 -: LB];
  assign rd_limit = rd_data_r[LB-1:0];
  assign need     = NW'(rd_load) + NW'(cfg.reserved);
  assign hit      = need < NW'(rd_limit);

  assign slot_ok = 32'(q_item.slot) < MAX_SERVERS;
  assign wr_addr = SW'(q_item.slot);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_item.req_type == REQ_WRITE) ? BK_EMIT : BK_DIV;
        end
      end
      BK_DIV: begin
        if (div_done) begin
          state_nxt = BK_READ;
        end
      end
      BK_READ: begin
        state_nxt = BK_CHECK;
      end
      BK_CHECK: begin
        state_nxt = (hit || last_probe) ? BK_EMIT : BK_READ;
      end
      BK_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    q_ready  = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        q_ready = 1'b1;
        mem_we  = q_valid && (q_item.req_type == REQ_WRITE) && slot_ok;
      end
      BK_EMIT: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        q_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[wr_addr] <= {q_item.id, LB'(q_item.load), LB'(q_item.limit)};
    end
    rd_data_r <= tbl_mem[pos_r];
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      BK_IDLE: begin
        rem_r        <= '0;
        dvd_r        <= q_item.bucket[HB-1:0];
        div_cnt_r    <= DCW'(HB);
        k_r          <= '0;
        res_status_r <= ST_WRITTEN;
        res_id_r     <= '0;
        res_slot_r   <= '0;
      end
      BK_DIV: begin
        rem_r     <= rem_nxt;
        dvd_r     <= dvd_r << 1;
        div_cnt_r <= div_cnt_r - DCW'(1);
        if (div_done) begin
          pos_r <= SW'(rem_nxt);
        end
      end
      BK_CHECK: begin
        priority if (hit) begin
          res_status_r <= ST_SELECTED;
          res_id_r     <= rd_id;
          res_slot_r   <= pos_wide[SLOT_W-1:0];
        end else if (last_probe) begin
          res_status_r <= ST_NONE;
          res_id_r     <= '0;
          res_slot_r   <= '0;
        end else begin
          pos_r <= pos_wrap;
          k_r   <= k_r + CW'(1);
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_slot_r   <= res_slot_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_chosen_id   = out_id_r;
  assign out_chosen_slot = out_slot_r;

endmodule
`default_nettype wire

// File: src/source_hash_server_select.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Source hash server select
// Hashes a source address onto a table of servers and returns the first
// server, probing forward from the hashed slot, that still has headroom.
// ----------------------------------------------------------------------------
// A write transaction stores one table slot and returns status written; a
// select transaction returns the chosen server or status none. The front end
// registers each transaction with its hashed bucket and a two-entry queue
// lets it keep accepting while the back end works. The back end handles one
// transaction at a time: a select first forms the bucket remainder one bit
// per cycle and then probes slots, each probed slot costing one registered
// table read and one check. Configuration writes take effect at once; the
// user must make them while no transaction is in flight, as the block itself
// does not enforce this.
module source_hash_server_select #(
  parameter int MAX_SERVERS  = 16,
  parameter int HASH_BUCKETS = 256,
  parameter int LOAD_BITS    = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_req_type,
  input  wire logic [shs_pkg::ADDR_W-1:0]     in_source_address,
  input  wire logic [shs_pkg::SLOT_W-1:0]     in_slot_index,
  input  wire logic [shs_pkg::ID_W-1:0]       in_entry_id,
  input  wire logic [shs_pkg::ENTRY_W-1:0]    in_entry_load,
  input  wire logic [shs_pkg::ENTRY_W-1:0]    in_entry_limit,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [shs_pkg::STATUS_W-1:0]        out_status,
  output logic [shs_pkg::ID_W-1:0]            out_chosen_id,
  output logic [shs_pkg::SLOT_W-1:0]          out_chosen_slot,
  input  wire logic                           cfg_we,
  input  wire logic [shs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [shs_pkg::RES_W-1:0]      cfg_wdata
);
  import shs_pkg::*;

  shs_cfg_t  cfg_r;
  logic      f_valid;
  logic      q_in_ready;
  shs_item_t f_item;
  logic      q_valid;
  logic      q_ready;
  shs_item_t q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.server_count <= SC_W'(1);
      cfg_r.reserved     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SERVER_COUNT: cfg_r.server_count <= cfg_wdata[SC_W-1:0];
        CFG_RESERVED:     cfg_r.reserved     <= cfg_wdata;
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

  shs_front #(
    .HASH_BUCKETS(HASH_BUCKETS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_source_address(in_source_address),
    .in_slot_index    (in_slot_index),
    .in_entry_id      (in_entry_id),
    .in_entry_load    (in_entry_load),
    .in_entry_limit   (in_entry_limit),
    .f_valid          (f_valid),
    .f_ready          (q_in_ready),
    .f_item           (f_item)
  );

  shs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(f_valid),
    .wr_ready(q_in_ready),
    .wr_item (f_item),
    .rd_valid(q_valid),
    .rd_ready(q_ready),
    .rd_item (q_item)
  );

  shs_back #(
    .MAX_SERVERS (MAX_SERVERS),
    .HASH_BUCKETS(HASH_BUCKETS),
    .LOAD_BITS   (LOAD_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_item         (q_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_chosen_id  (out_chosen_id),
    .out_chosen_slot(out_chosen_slot)
  );

`ifndef ASSERT_OFF
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_SELECTED || out_status == ST_NONE ||
                   out_status == ST_WRITTEN))
    else $error("result carries an unknown status code");

  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_SELECTED |->
      out_chosen_id == '0 && out_chosen_slot == '0)
    else $error("identifier or slot is nonzero without a selected server");

  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    f_valid && !q_in_ready |=> f_valid)
    else $error("front end dropped a transaction while the queue was full");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire

// File: dv/source_hash_server_select_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Source hash server select testbench
// Fills the server table through write transactions, then sends select
// transactions with random addresses under a range of server counts and
// reserved capacities. A scoreboard predicts the status, identifier and slot
// of every result and compares them in order, while both handshakes idle at
// random and the receiver twice holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module source_hash_server_select_test;
  import shs_pkg::*;

  localparam int SLOTS       = 16;
  localparam int BUCKETS     = 256;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 110;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    logic                req_type;
    logic [ADDR_W-1:0]   addr;
    logic [SLOT_W-1:0]   slot;
    logic [ID_W-1:0]     id;
    logic [ENTRY_W-1:0]  load;
    logic [ENTRY_W-1:0]  limit;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic [SLOT_W-1:0]   slot;
  } server_pick_t;

  class pick_scoreboard;
    logic [ID_W-1:0]    server_ids [SLOTS];
    logic [ENTRY_W-1:0] loads [SLOTS];
    logic [ENTRY_W-1:0] limits [SLOTS];
    logic [SC_W-1:0]    server_count = 1;
    logic [RES_W-1:0]   reserved = 0;
    server_pick_t       expected_picks[$];
    int                 errors = 0;
    int                 checked = 0;
    int                 selected = 0;
    int                 unavailable = 0;
    int                 written = 0;

    function void set_config(logic [SC_W-1:0] count, logic [RES_W-1:0] reserve);
      server_count = count;
      reserved = reserve;
    endfunction

    function int pending();
      return expected_picks.size();
    endfunction

    function void note_request(request_t rq);
      server_pick_t pick;
      logic [ADDR_W-1:0] product;
      logic [ENTRY_W:0] need;
      int n;
      int pos;
      int k;
      bit found;
      pick = '0;
      if (rq.req_type == REQ_WRITE) begin
        server_ids[rq.slot] = rq.id;
        loads[rq.slot] = rq.load;
        limits[rq.slot] = rq.limit;
        pick.status = ST_WRITTEN;
      end else begin
        n = (server_count == 0) ? 1 : ((server_count > SLOTS) ? SLOTS : int'(server_count));
        product = rq.addr * GOLDEN_MULT;
        pos = int'(product & ADDR_W'(BUCKETS - 1)) % n;
        found = 0;
        pick.status = ST_NONE;
        for (k = 0; k < n && !found; k++) begin
          need = {1'b0, loads[pos]} + {1'b0, reserved};
          if (need < {1'b0, limits[pos]}) begin
            found = 1;
            pick.status = ST_SELECTED;
            pick.id = server_ids[pos];
            pick.slot = SLOT_W'(pos);
          end else begin
            pos = (pos + 1) % n;
          end
        end
      end
      expected_picks.push_back(pick);
    endfunction

    task report_mismatch(string what, int got, int want);
      if (errors < 40)
        $display("result %0d: %s got 0x%0h, expected 0x%0h", checked, what, got, want);
      errors++;
    endtask

    task check_pick(logic [STATUS_W-1:0] status, logic [ID_W-1:0] id,
                    logic [SLOT_W-1:0] slot);
      server_pick_t want;
      if (expected_picks.size() == 0) begin
        report_mismatch("result with no pending transaction, status", status, 0);
      end else begin
        want = expected_picks.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (id !== want.id) report_mismatch("chosen_id", id, want.id);
        if (slot !== want.slot) report_mismatch("chosen_slot", slot, want.slot);
        case (want.status)
          ST_SELECTED: selected++;
          ST_NONE:     unavailable++;
          default:     written++;
        endcase
      end
      checked++;
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_req_type;
  logic [ADDR_W-1:0]    in_source_address;
  logic [SLOT_W-1:0]    in_slot_index;
  logic [ID_W-1:0]      in_entry_id;
  logic [ENTRY_W-1:0]   in_entry_load;
  logic [ENTRY_W-1:0]   in_entry_limit;
  logic                 out_valid;
  logic                 out_ready;
  logic [STATUS_W-1:0]  out_status;
  logic [ID_W-1:0]      out_chosen_id;
  logic [SLOT_W-1:0]    out_chosen_slot;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RES_W-1:0]     cfg_wdata;

  pick_scoreboard board = new();
  bit             steady = 0;
  int             settings_applied = 0;
  int unsigned    cycle_count = 0;

  source_hash_server_select #(
    .MAX_SERVERS(SLOTS),
    .HASH_BUCKETS(BUCKETS),
    .LOAD_BITS(ENTRY_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_source_address(in_source_address),
    .in_slot_index(in_slot_index),
    .in_entry_id(in_entry_id),
    .in_entry_load(in_entry_load),
    .in_entry_limit(in_entry_limit),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_chosen_id(out_chosen_id),
    .out_chosen_slot(out_chosen_slot),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending", cycle_count,
               board.pending());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic request_t write_request(int slot, logic [ID_W-1:0] id,
                                             logic [ENTRY_W-1:0] load,
                                             logic [ENTRY_W-1:0] limit);
    request_t rq;
    rq = '0;
    rq.req_type = REQ_WRITE;
    rq.addr = $urandom;
    rq.slot = SLOT_W'(slot);
    rq.id = id;
    rq.load = load;
    rq.limit = limit;
    return rq;
  endfunction

  function automatic request_t select_request(logic [ADDR_W-1:0] addr);
    request_t rq;
    rq = '0;
    rq.req_type = REQ_SELECT;
    rq.addr = addr;
    rq.slot = SLOT_W'($urandom);
    rq.id = ID_W'($urandom);
    rq.load = ENTRY_W'($urandom);
    rq.limit = ENTRY_W'($urandom);
    return rq;
  endfunction

  function automatic request_t random_request();
    logic [ENTRY_W-1:0] load;
    logic [ENTRY_W-1:0] limit;
    if ($urandom_range(0, 3) != 0) return select_request($urandom);
    if ($urandom_range(0, 4) == 0) begin
      load = ENTRY_W'($urandom);
      limit = ENTRY_W'($urandom);
    end else begin
      load = ENTRY_W'($urandom_range(0, 400));
      limit = ENTRY_W'($urandom_range(0, 800));
    end
    return write_request($urandom_range(0, SLOTS - 1), ID_W'($urandom), load, limit);
  endfunction

  task automatic apply_config(logic [SC_W-1:0] count, logic [RES_W-1:0] reserve);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SERVER_COUNT;
    cfg_wdata <= {(RES_W - SC_W)'($urandom), count};
    @(posedge clk);
    cfg_index <= CFG_RESERVED;
    cfg_wdata <= reserve;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_config(count, reserve);
    settings_applied++;
  endtask

  task automatic send_request(request_t rq);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rq.req_type;
    in_source_address <= rq.addr;
    in_slot_index <= rq.slot;
    in_entry_id <= rq.id;
    in_entry_load <= rq.load;
    in_entry_limit <= rq.limit;
    do @(posedge clk); while (!in_ready);
    board.note_request(rq);
  endtask

  task automatic end_phase();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (board.checked == 200 || board.checked == 750)
        stall = LONG_HOLD;
      else
        stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_pick(out_status, out_chosen_id, out_chosen_slot);
    end
  end

  initial begin
    int p;
    int s;
    logic [SC_W-1:0] count;
    logic [RES_W-1:0] reserve;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req_type <= REQ_SELECT;
    in_source_address <= '0;
    in_slot_index <= '0;
    in_entry_id <= '0;
    in_entry_load <= '0;
    in_entry_limit <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_SERVER_COUNT;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apply_config(SLOTS, 0);
    for (s = 0; s < SLOTS; s++) begin
      case (s)
        0:  send_request(write_request(s, 16'h0000, 16'h0000, 16'h0000));
        1:  send_request(write_request(s, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        2:  send_request(write_request(s, 16'h1234, 16'h0000, 16'hFFFF));
        15: send_request(write_request(s, 16'hFFFF, 16'h0000, 16'h0001));
        default: send_request(write_request(s, ID_W'(16'h0100 + s), ENTRY_W'(s * 10),
                                            ENTRY_W'(s * 15)));
      endcase
    end
    send_request(select_request(32'h0000_0000));
    send_request(select_request(32'hFFFF_FFFF));
    send_request(select_request(32'h0000_0001));
    end_phase();

    // Full reservation leaves no server with headroom.
    apply_config(SLOTS, 16'hFFFF);
    send_request(select_request($urandom));
    send_request(select_request(32'h8000_0000));
    end_phase();

    apply_config(0, 0);
    send_request(select_request($urandom));
    send_request(select_request(32'hFFFF_FFFF));
    end_phase();

    apply_config(31, 5);
    send_request(select_request($urandom));
    send_request(select_request(32'h0000_0003));
    end_phase();

    for (p = 0; p < PHASES; p++) begin
      steady = (p == 3 || p == 7);
      case (p)
        0: begin count = SLOTS; reserve = 0; end
        1: begin count = 1; reserve = RES_W'($urandom_range(0, 300)); end
        2: begin count = 31; reserve = RES_W'($urandom_range(0, 300)); end
        3: begin count = 0; reserve = 0; end
        4: begin count = SLOTS; reserve = 16'hFFFF; end
        9: begin count = SC_W'($urandom_range(17, 31)); reserve = RES_W'($urandom_range(0, 300)); end
        default: begin
          count = SC_W'($urandom_range(2, SLOTS));
          reserve = ($urandom_range(0, 3) == 0) ? RES_W'($urandom) :
                                                   RES_W'($urandom_range(0, 300));
        end
      endcase
      apply_config(count, reserve);
      repeat (PHASE_ITEMS) send_request(random_request());
      end_phase();
    end
    steady = 0;

    repeat (64) @(posedge clk);
    $display("Checked %0d results: %0d selections, %0d with no server free, %0d slot writes.",
             board.checked, board.selected, board.unavailable, board.written);
    $display("Ran under %0d register settings, server counts 0 to 31, reserve 0 to 65535.",
             settings_applied);
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches found", board.errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/shs_pkg.sv
src/shs_front.sv
src/shs_queue.sv
src/shs_back.sv
src/source_hash_server_select.sv
dv/source_hash_server_select_test.sv
